// File: hdl/cihp_pkg.sv
// ----------------------------------------------------------------------------
// cihp_pkg
// Shared types and constants for the cache image header parser.
// ----------------------------------------------------------------------------
package cihp_pkg;

   localparam int MAGIC_BYTES_DEF = 8;
   localparam int COUNT_BITS_DEF  = 16;
   localparam int NUM_STRINGS     = 5;
   localparam int CSR_IDX_W       = 2;
   localparam int CSR_DATA_W      = 64;

   localparam logic [1:0] KIND_DATA    = 2'd0;
   localparam logic [1:0] KIND_END     = 2'd1;
   localparam logic [1:0] KIND_RESTART = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_MAGIC    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MARK     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_VER  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CHK_TAG  = 2'd3;

   localparam logic [4:0] FC_VERSION  = 5'd0;
   localparam logic [4:0] FC_PTR      = 5'd1;
   localparam logic [4:0] FC_STRING0  = 5'd2;
   localparam logic [4:0] FC_IMAGE    = 5'd7;
   localparam logic [4:0] FC_CHECKSUM = 5'd8;
   localparam logic [4:0] FC_DSTART   = 5'd9;
   localparam logic [4:0] FC_DEND     = 5'd10;
   localparam logic [4:0] FC_FLAGS    = 5'd11;
   localparam logic [4:0] FC_NAME     = 5'd12;
   localparam logic [4:0] FC_UUIDHI   = 5'd13;
   localparam logic [4:0] FC_UUIDLO   = 5'd14;
   localparam logic [4:0] FC_BUILDHI  = 5'd15;
   localparam logic [4:0] FC_BUILDLO  = 5'd16;
   localparam logic [4:0] FC_DEPLEN   = 5'd17;
   localparam logic [4:0] FC_DONE     = 5'd18;
   localparam logic [4:0] FC_ERROR    = 5'd19;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_TRUNC     = 3'd1;
   localparam logic [2:0] ST_BAD_MAGIC = 3'd2;
   localparam logic [2:0] ST_BAD_MARK  = 3'd3;
   localparam logic [2:0] ST_BAD_NAME  = 3'd4;
   localparam logic [2:0] ST_VAL_FAIL  = 3'd5;

   typedef struct packed {
      logic [4:0]  field_code;
      logic [63:0] field_value;
      logic [62:0] field_offset;
      logic [15:0] module_number;
      logic        list_select;
      logic        string_last;
      logic [2:0]  status;
   } rsp_word_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  data_byte;
      logic [62:0] here;
   } tok_type;

   localparam int TOK_W = $bits(tok_type);
   localparam int RSP_W = $bits(rsp_word_type);

endpackage

// File: hdl/cihp_stream_if.sv
// ----------------------------------------------------------------------------
// cihp_stream_if
// Valid/ready channel carrying a packed payload.
// ----------------------------------------------------------------------------
interface cihp_stream_if #(
   parameter int W = 8
);
   logic         valid;
   logic         ready;
   logic [W-1:0] payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: hdl/cihp_front.sv
// ----------------------------------------------------------------------------
// cihp_front
// Accepts words, drops unused kinds, stamps each data byte with its position.
// ----------------------------------------------------------------------------
module cihp_front (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_kind,
   input  logic [7:0] req_data_byte,
   output logic       tok_valid,
   input  logic       tok_ready,
   output cihp_pkg::tok_type tok
);
   logic [62:0] pos_ff, pos_in;
   logic        acc;
   logic        keep;

   // stamping and dropping happens here, queue follows
   assign req_ready = tok_ready;
   assign acc       = req_valid && req_ready;
   assign keep      = req_kind != 2'd3;

   assign tok_valid      = req_valid && keep;
   assign tok.kind       = req_kind;
   assign tok.data_byte  = req_data_byte;
   assign tok.here       = pos_ff;

   always_comb begin
      pos_in = pos_ff;
      if (acc && req_kind == cihp_pkg::KIND_RESTART) begin
         pos_in = '0;
      end else if (acc && req_kind == cihp_pkg::KIND_DATA) begin
         pos_in = pos_ff + 63'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) pos_ff <= '0;
      else       pos_ff <= pos_in;
   end
endmodule

// File: hdl/cihp_queue.sv
// ----------------------------------------------------------------------------
// cihp_queue
// Two-entry word queue between the front and back parts.
// ----------------------------------------------------------------------------
module cihp_queue #(
   parameter int W = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  logic [W-1:0] in_data,
   output logic         out_valid,
   input  logic         out_ready,
   output logic [W-1:0] out_data
);
   logic [W-1:0] mem_ff [2];
   logic         wr_ff, rd_ff;
   logic [1:0]   cnt_ff;
   logic         push, pop;

   assign in_ready  = cnt_ff != 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign out_data  = mem_ff[rd_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= in_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wr_ff <= ~wr_ff;
         if (pop)  rd_ff <= ~rd_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   assert property (@(posedge clock) disable iff (reset) cnt_ff != 2'd3)
      else $error("queue count out of range");
   assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2 && !out_ready) |=> cnt_ff == 2'd2)
      else $error("full queue lost a word");
   assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0 && !in_valid) |=> cnt_ff == 2'd0)
      else $error("empty queue invented a word");
endmodule

// File: hdl/cihp_back.sv
// ----------------------------------------------------------------------------
// cihp_back
// Header field state machine; emits result words for finished fields, for each string and name byte, and on errors.
// ----------------------------------------------------------------------------
module cihp_back #(
   parameter int MAGIC_BYTES = cihp_pkg::MAGIC_BYTES_DEF,
   parameter int COUNT_BITS  = cihp_pkg::COUNT_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        tok_valid,
   output logic        tok_ready,
   input  cihp_pkg::tok_type tok,
   input  logic [63:0] magic_word,
   input  logic [15:0] order_mark,
   input  logic [15:0] min_version,
   input  logic [31:0] checksum_tag,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output cihp_pkg::rsp_word_type rsp
);
   typedef enum logic [19:0] {
      PH_MAGIC    = 20'h00001, PH_VERSION = 20'h00002, PH_MARK   = 20'h00004,
      PH_PTR      = 20'h00008, PH_STRING  = 20'h00010, PH_IMAGE  = 20'h00020,
      PH_CHECKSUM = 20'h00040, PH_DSTART  = 20'h00080, PH_DEND   = 20'h00100,
      PH_FLAGS    = 20'h00200, PH_NAMELEN = 20'h00400, PH_NAME   = 20'h00800,
      PH_UUIDHI   = 20'h01000, PH_UUIDLO  = 20'h02000, PH_BUILDHI = 20'h04000,
      PH_BUILDLO  = 20'h08000, PH_DEPLEN  = 20'h10000, PH_DEPSKIP = 20'h20000,
      PH_DONE     = 20'h40000, PH_HALT    = 20'h80000
   } phase_type;

   localparam logic [63:0] MAGIC_MASK = {64{1'b1}} >> (64 - 8 * MAGIC_BYTES);
   localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

   phase_type   phase_ff, phase_in;
   logic [3:0]  bif_ff, bif_in;
   logic [63:0] val_ff, val_in;
   logic [62:0] start_ff, start_in;
   logic [2:0]  strn_ff, strn_in;
   logic [30:0] nrem_ff, nrem_in;
   logic [63:0] skip_ff, skip_in;
   logic [COUNT_BITS-1:0] cnt_ff, cnt_in;
   logic        req_ff, req_in;
   logic        img_ff, img_in;
   logic        vbad_ff, vbad_in;
   logic        ov_ff;
   cihp_pkg::rsp_word_type ow_ff;

   logic        take, emit;
   cihp_pkg::rsp_word_type w;
   logic [63:0] v;
   logic [62:0] st;
   logic [3:0]  nbytes, bif_nx;
   logic [30:0] nrem_dec;
   logic [63:0] skip_dec;
   logic [15:0] modnum;

   assign tok_ready = !ov_ff || rsp_ready;
   assign take      = tok_valid && tok_ready;
   assign rsp_valid = ov_ff;
   assign rsp       = ow_ff;
   assign modnum    = 16'(cnt_ff);

   always_comb begin
      unique case (phase_ff)
         PH_MAGIC:                    nbytes = 4'(MAGIC_BYTES);
         PH_VERSION, PH_MARK:         nbytes = 4'd2;
         PH_PTR, PH_IMAGE, PH_FLAGS:  nbytes = 4'd1;
         PH_NAMELEN:                  nbytes = 4'd4;
         default:                     nbytes = 4'd8;
      endcase
   end

   always_comb begin
      phase_in = phase_ff; bif_in = bif_ff; val_in = val_ff; start_in = start_ff;
      strn_in = strn_ff; nrem_in = nrem_ff; skip_in = skip_ff; cnt_in = cnt_ff;
      req_in = req_ff; img_in = img_ff; vbad_in = vbad_ff;
      emit = 1'b0;
      w = '0;
      v = val_ff;
      st = start_ff;
      bif_nx = bif_ff + 4'd1;
      nrem_dec = (nrem_ff != '0) ? nrem_ff - 31'd1 : nrem_ff;
      skip_dec = (skip_ff != '0) ? skip_ff - 64'd1 : skip_ff;
      if (bif_ff == 4'd0) begin
         st = tok.here;
         v  = 64'(tok.data_byte);
      end else begin
         v = val_ff | (64'(tok.data_byte) << {bif_ff[2:0], 3'b000});
      end
      if (take) begin
         priority if (tok.kind == cihp_pkg::KIND_RESTART) begin
            phase_in = PH_MAGIC; bif_in = '0; val_in = '0; start_in = '0;
            strn_in = '0; nrem_in = '0; skip_in = '0; cnt_in = '0;
            req_in = 1'b0; img_in = 1'b0; vbad_in = 1'b0;
         end else if (phase_ff == PH_DONE || phase_ff == PH_HALT) begin
         end else if (tok.kind == cihp_pkg::KIND_END) begin
            emit = 1'b1; phase_in = PH_HALT;
            w.field_code = cihp_pkg::FC_ERROR; w.field_offset = tok.here;
            w.status = cihp_pkg::ST_TRUNC;
         end else if (phase_ff == PH_STRING) begin
            emit = 1'b1;
            w.field_code = cihp_pkg::FC_STRING0 + 5'(strn_ff);
            w.field_value = 64'(tok.data_byte);
            w.field_offset = tok.here;
            if (tok.data_byte == 8'd0) begin
               w.string_last = 1'b1;
               if (strn_ff == 3'(cihp_pkg::NUM_STRINGS - 1)) begin
                  strn_in = '0; phase_in = PH_IMAGE;
               end else begin
                  strn_in = strn_ff + 3'd1;
               end
            end
         end else if (phase_ff == PH_NAME) begin
            emit = 1'b1; nrem_in = nrem_dec;
            w.field_code = cihp_pkg::FC_NAME; w.field_value = 64'(tok.data_byte);
            w.field_offset = tok.here; w.module_number = modnum; w.list_select = req_ff;
            w.string_last = nrem_dec == '0;
            if (nrem_dec == '0) phase_in = PH_UUIDHI;
         end else if (phase_ff == PH_DEPSKIP) begin
            skip_in = skip_dec;
            if (skip_dec == '0) begin
               emit = 1'b1; req_in = 1'b1; cnt_in = '0; phase_in = PH_NAMELEN;
               w.field_code = cihp_pkg::FC_DEPLEN; w.field_value = val_ff + 64'd8;
               w.field_offset = start_ff;
            end
         end else begin
            val_in = v; start_in = st;
            if (bif_nx < nbytes) begin
               bif_in = bif_nx;
            end else begin
               bif_in = '0;
               w.field_value = v; w.field_offset = st;
               unique case (phase_ff)
                  PH_MAGIC: begin
                     if (v != (magic_word & MAGIC_MASK)) begin
                        emit = 1'b1; phase_in = PH_HALT; w.field_value = '0;
                        w.field_code = cihp_pkg::FC_ERROR; w.status = cihp_pkg::ST_BAD_MAGIC;
                     end else phase_in = PH_VERSION;
                  end
                  PH_VERSION: begin
                     if (v[15:0] < min_version) vbad_in = 1'b1;
                     phase_in = PH_MARK; emit = 1'b1; w.field_code = cihp_pkg::FC_VERSION;
                  end
                  PH_MARK: begin
                     if (v[15:0] != order_mark) begin
                        emit = 1'b1; phase_in = PH_HALT; w.field_value = '0;
                        w.field_code = cihp_pkg::FC_ERROR; w.status = cihp_pkg::ST_BAD_MARK;
                     end else phase_in = PH_PTR;
                  end
                  PH_PTR: begin
                     phase_in = PH_STRING; strn_in = '0;
                     emit = 1'b1; w.field_code = cihp_pkg::FC_PTR;
                  end
                  PH_IMAGE: begin
                     img_in = v != '0; phase_in = PH_CHECKSUM;
                     emit = 1'b1; w.field_code = cihp_pkg::FC_IMAGE;
                  end
                  PH_CHECKSUM: begin
                     if (v[63:32] != '0 && v[63:32] != checksum_tag) vbad_in = 1'b1;
                     phase_in = PH_DSTART; emit = 1'b1; w.field_code = cihp_pkg::FC_CHECKSUM;
                  end
                  PH_DSTART: begin
                     phase_in = PH_DEND; emit = 1'b1; w.field_code = cihp_pkg::FC_DSTART;
                  end
                  PH_DEND: begin
                     phase_in = PH_FLAGS; emit = 1'b1; w.field_code = cihp_pkg::FC_DEND;
                  end
                  PH_FLAGS: begin
                     req_in = img_ff; cnt_in = '0; phase_in = PH_NAMELEN;
                     emit = 1'b1; w.field_code = cihp_pkg::FC_FLAGS;
                  end
                  PH_NAMELEN: begin
                     priority if (v[31:0] == '0) begin
                        if (!req_ff) phase_in = PH_DEPLEN;
                        else begin
                           phase_in = PH_DONE; emit = 1'b1;
                           w.field_code = cihp_pkg::FC_DONE;
                           w.field_value = 64'(cnt_ff); w.list_select = 1'b1;
                           w.status = vbad_ff ? cihp_pkg::ST_VAL_FAIL : cihp_pkg::ST_OK;
                        end
                     end else if (v[31]) begin
                        emit = 1'b1; phase_in = PH_HALT; w.field_value = '0;
                        w.field_code = cihp_pkg::FC_ERROR; w.status = cihp_pkg::ST_BAD_NAME;
                     end else begin
                        nrem_in = v[30:0]; phase_in = PH_NAME;
                     end
                  end
                  PH_UUIDHI: begin
                     phase_in = PH_UUIDLO; emit = 1'b1; w.field_code = cihp_pkg::FC_UUIDHI;
                     w.module_number = modnum; w.list_select = req_ff;
                  end
                  PH_UUIDLO: begin
                     phase_in = req_ff ? PH_BUILDHI : PH_BUILDLO;
                     emit = 1'b1; w.field_code = cihp_pkg::FC_UUIDLO;
                     w.module_number = modnum; w.list_select = req_ff;
                  end
                  PH_BUILDHI: begin
                     phase_in = PH_BUILDLO; emit = 1'b1; w.field_code = cihp_pkg::FC_BUILDHI;
                     w.module_number = modnum; w.list_select = req_ff;
                  end
                  PH_BUILDLO: begin
                     emit = 1'b1; w.field_code = cihp_pkg::FC_BUILDLO;
                     w.module_number = modnum; w.list_select = req_ff;
                     if (cnt_ff != CNT_MAX) cnt_in = cnt_ff + 1'b1;
                     phase_in = PH_NAMELEN;
                  end
                  PH_DEPLEN: begin
                     if (v == '0) begin
                        req_in = 1'b1; cnt_in = '0; phase_in = PH_NAMELEN;
                        emit = 1'b1; w.field_code = cihp_pkg::FC_DEPLEN;
                        w.field_value = 64'd8;
                     end else begin
                        skip_in = v; phase_in = PH_DEPSKIP;
                     end
                  end
                  default: phase_in = PH_HALT;
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_MAGIC; bif_ff <= '0; val_ff <= '0; start_ff <= '0;
         strn_ff <= '0; nrem_ff <= '0; skip_ff <= '0; cnt_ff <= '0;
         req_ff <= 1'b0; img_ff <= 1'b0; vbad_ff <= 1'b0; ov_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in; bif_ff <= bif_in; val_ff <= val_in; start_ff <= start_in;
         strn_ff <= strn_in; nrem_ff <= nrem_in; skip_ff <= skip_in; cnt_ff <= cnt_in;
         req_ff <= req_in; img_ff <= img_in; vbad_ff <= vbad_in;
         if (take) ov_ff <= emit;
         else if (rsp_ready) ov_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take && emit) ow_ff <= w;
   end

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
      else $error("result word changed while stalled");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp.status != cihp_pkg::ST_OK) |->
      (rsp.field_code == cihp_pkg::FC_DONE || rsp.field_code == cihp_pkg::FC_ERROR))
      else $error("status on a plain field");
   assert property (@(posedge clock) disable iff (reset)
      (take && emit && w.field_code == cihp_pkg::FC_ERROR) |=> phase_ff == PH_HALT)
      else $error("error did not halt parsing");
endmodule

// File: hdl/cache_image_header_parser_unit.sv
// Path: an accepted word is registered in the two-entry queue, and its result in the output register.
// Throughput: one word per cycle while the result side does not stall; the two-entry queue
// and the output register let front and back stall independently.
// Reset: synchronous, active high; clears parse state and restores the
// register defaults (magic 0, order mark 0xFEFF, min version 0, tag 0).
// ----------------------------------------------------------------------------
// cache_image_header_parser_unit
// Parses a cache image header byte stream into field result words.
// ----------------------------------------------------------------------------
module cache_image_header_parser_unit #(
   parameter int MAGIC_BYTES = cihp_pkg::MAGIC_BYTES_DEF,
   parameter int COUNT_BITS  = cihp_pkg::COUNT_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [4:0]  rsp_field_code,
   output logic [63:0] rsp_field_value,
   output logic [62:0] rsp_field_offset,
   output logic [15:0] rsp_module_number,
   output logic        rsp_list_select,
   output logic        rsp_string_last,
   output logic [2:0]  rsp_status,
   input  logic        csr_we,
   input  logic [cihp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [cihp_pkg::CSR_DATA_W-1:0] csr_wdata
);
   logic [63:0] magic_ff;
   logic [15:0] mark_ff, minv_ff;
   logic [31:0] tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff <= '0; mark_ff <= 16'hFEFF; minv_ff <= '0; tag_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            cihp_pkg::CSR_MAGIC:   magic_ff <= csr_wdata;
            cihp_pkg::CSR_MARK:    mark_ff  <= csr_wdata[15:0];
            cihp_pkg::CSR_MIN_VER: minv_ff  <= csr_wdata[15:0];
            cihp_pkg::CSR_CHK_TAG: tag_ff   <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   logic              f_valid, f_ready, b_valid, b_ready;
   cihp_pkg::tok_type f_tok, b_tok;
   cihp_pkg::rsp_word_type rw;

   cihp_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_kind, .req_data_byte,
      .tok_valid(f_valid), .tok_ready(f_ready), .tok(f_tok)
   );

   cihp_queue #(.W(cihp_pkg::TOK_W)) u_queue (
      .clock, .reset, .in_valid(f_valid), .in_ready(f_ready), .in_data(f_tok),
      .out_valid(b_valid), .out_ready(b_ready), .out_data(b_tok)
   );

   cihp_back #(.MAGIC_BYTES(MAGIC_BYTES), .COUNT_BITS(COUNT_BITS)) u_back (
      .clock, .reset, .tok_valid(b_valid), .tok_ready(b_ready), .tok(b_tok),
      .magic_word(magic_ff), .order_mark(mark_ff), .min_version(minv_ff),
      .checksum_tag(tag_ff), .rsp_valid, .rsp_ready, .rsp(rw)
   );

   assign rsp_field_code    = rw.field_code;
   assign rsp_field_value   = rw.field_value;
   assign rsp_field_offset  = rw.field_offset;
   assign rsp_module_number = rw.module_number;
   assign rsp_list_select   = rw.list_select;
   assign rsp_string_last   = rw.string_last;
   assign rsp_status        = rw.status;
endmodule

// File: test/cihp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cihp_checker
// Watches the byte and result channels of the header parser, tracks the
// register writes, predicts every result word and compares field by field.
// ----------------------------------------------------------------------------
module cihp_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic [1:0]                      req_kind,
   input  logic [7:0]                      req_data_byte,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  cihp_pkg::rsp_word_type          rsp_word,
   input  logic                            csr_we,
   input  logic [cihp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [cihp_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                              mismatches,
   output int                              pending
);

   typedef enum logic [4:0] {
      P_MAGIC, P_VERSION, P_MARK, P_PTR, P_STRING, P_IMAGE, P_CHECKSUM,
      P_DSTART, P_DEND, P_FLAGS, P_NAMELEN, P_NAME, P_UUIDHI, P_UUIDLO,
      P_BUILDHI, P_BUILDLO, P_DEPLEN, P_DEPSKIP, P_DONE, P_HALT
   } parse_phase_type;

   localparam logic [1:0] KIND_UNUSED = 2'd3;

   // register copies
   logic [63:0] magic_reg;
   logic [15:0] mark_reg;
   logic [15:0] min_ver_reg;
   logic [31:0] tag_reg;

   // parser state
   parse_phase_type phase;
   int unsigned     byte_cnt;
   logic [63:0]     acc;
   logic [62:0]     pos;
   logic [62:0]     fstart;
   int unsigned     str_num;
   logic [30:0]     name_left;
   logic [63:0]     skip_left;
   logic [15:0]     entry_cnt;
   logic            in_req;
   logic            img;
   logic            val_bad;

   cihp_pkg::rsp_word_type field_words_q[$];

   assign pending = field_words_q.size();

   task automatic push_word(logic [4:0] code, logic [63:0] value, logic [62:0] offset,
                            logic [15:0] modnum, logic list, logic last, logic [2:0] status);
      cihp_pkg::rsp_word_type w;
      w.field_code    = code;
      w.field_value   = value;
      w.field_offset  = offset;
      w.module_number = modnum;
      w.list_select   = list;
      w.string_last   = last;
      w.status        = status;
      field_words_q.push_back(w);
   endtask

   task automatic clear_parse();
      phase     = P_MAGIC;
      byte_cnt  = 0;
      acc       = '0;
      pos       = '0;
      fstart    = '0;
      str_num   = 0;
      name_left = '0;
      skip_left = '0;
      entry_cnt = '0;
      in_req    = 1'b0;
      img       = 1'b0;
      val_bad   = 1'b0;
   endtask

   task automatic start_list(logic required);
      in_req    = required;
      entry_cnt = '0;
      phase     = P_NAMELEN;
   endtask

   task automatic halt_with(logic [62:0] offset, logic [2:0] status);
      phase = P_HALT;
      push_word(cihp_pkg::FC_ERROR, '0, offset, '0, 1'b0, 1'b0, status);
   endtask

   task automatic close_field();
      byte_cnt = 0;
      case (phase)
         P_MAGIC: begin
            if (acc != magic_reg) halt_with(fstart, cihp_pkg::ST_BAD_MAGIC);
            else phase = P_VERSION;
         end
         P_VERSION: begin
            if (acc < min_ver_reg) val_bad = 1'b1;
            phase = P_MARK;
            push_word(cihp_pkg::FC_VERSION, acc, fstart, '0, 1'b0, 1'b0, cihp_pkg::ST_OK);
         end
         P_MARK: begin
            if (acc != mark_reg) halt_with(fstart, cihp_pkg::ST_BAD_MARK);
            else phase = P_PTR;
         end
         P_PTR: begin
            phase   = P_STRING;
            str_num = 0;
            push_word(cihp_pkg::FC_PTR, acc, fstart, '0, 1'b0, 1'b0, cihp_pkg::ST_OK);
         end
         P_IMAGE: begin
            img   = (acc != 0);
            phase = P_CHECKSUM;
            push_word(cihp_pkg::FC_IMAGE, acc, fstart, '0, 1'b0, 1'b0, cihp_pkg::ST_OK);
         end
         P_CHECKSUM: begin
            if (acc[63:32] != 0 && acc[63:32] != tag_reg) val_bad = 1'b1;
            phase = P_DSTART;
            push_word(cihp_pkg::FC_CHECKSUM, acc, fstart, '0, 1'b0, 1'b0, cihp_pkg::ST_OK);
         end
         P_DSTART: begin
            phase = P_DEND;
            push_word(cihp_pkg::FC_DSTART, acc, fstart, '0, 1'b0, 1'b0, cihp_pkg::ST_OK);
         end
         P_DEND: begin
            phase = P_FLAGS;
            push_word(cihp_pkg::FC_DEND, acc, fstart, '0, 1'b0, 1'b0, cihp_pkg::ST_OK);
         end
         P_FLAGS: begin
            start_list(img);
            push_word(cihp_pkg::FC_FLAGS, acc, fstart, '0, 1'b0, 1'b0, cihp_pkg::ST_OK);
         end
         P_NAMELEN: begin
            if (acc == 0) begin
               if (!in_req) begin
                  phase = P_DEPLEN;
               end else begin
                  phase = P_DONE;
                  push_word(cihp_pkg::FC_DONE, {48'd0, entry_cnt}, fstart, '0, 1'b1, 1'b0,
                            val_bad ? cihp_pkg::ST_VAL_FAIL : cihp_pkg::ST_OK);
               end
            end else if (acc[31]) begin
               halt_with(fstart, cihp_pkg::ST_BAD_NAME);
            end else begin
               name_left = acc[30:0];
               phase     = P_NAME;
            end
         end
         P_UUIDHI: begin
            phase = P_UUIDLO;
            push_word(cihp_pkg::FC_UUIDHI, acc, fstart, entry_cnt, in_req, 1'b0,
                      cihp_pkg::ST_OK);
         end
         P_UUIDLO: begin
            phase = in_req ? P_BUILDHI : P_BUILDLO;
            push_word(cihp_pkg::FC_UUIDLO, acc, fstart, entry_cnt, in_req, 1'b0,
                      cihp_pkg::ST_OK);
         end
         P_BUILDHI: begin
            phase = P_BUILDLO;
            push_word(cihp_pkg::FC_BUILDHI, acc, fstart, entry_cnt, in_req, 1'b0,
                      cihp_pkg::ST_OK);
         end
         P_BUILDLO: begin
            push_word(cihp_pkg::FC_BUILDLO, acc, fstart, entry_cnt, in_req, 1'b0,
                      cihp_pkg::ST_OK);
            if (entry_cnt != 16'hFFFF) entry_cnt = entry_cnt + 1'b1;
            phase = P_NAMELEN;
         end
         P_DEPLEN: begin
            if (acc == 0) begin
               start_list(1'b1);
               push_word(cihp_pkg::FC_DEPLEN, 64'd8, fstart, '0, 1'b0, 1'b0, cihp_pkg::ST_OK);
            end else begin
               skip_left = acc;
               phase     = P_DEPSKIP;
            end
         end
         default: phase = P_HALT;
      endcase
   endtask

   task automatic parse_word(logic [1:0] kind, logic [7:0] b);
      logic [62:0] here;
      int unsigned nbytes;
      logic [4:0]  code;
      if (kind == cihp_pkg::KIND_RESTART) begin
         clear_parse();
         return;
      end
      if (kind == KIND_UNUSED || phase >= P_DONE) return;
      if (kind == cihp_pkg::KIND_END) begin
         halt_with(pos, cihp_pkg::ST_TRUNC);
         return;
      end
      here = pos;
      pos  = pos + 1'b1;
      if (phase == P_STRING) begin
         code = cihp_pkg::FC_STRING0 + 5'(str_num < cihp_pkg::NUM_STRINGS ? str_num : 0);
         if (b != 0) begin
            push_word(code, {56'd0, b}, here, '0, 1'b0, 1'b0, cihp_pkg::ST_OK);
         end else begin
            str_num++;
            if (str_num >= cihp_pkg::NUM_STRINGS) begin
               str_num = 0;
               phase   = P_IMAGE;
            end
            push_word(code, '0, here, '0, 1'b0, 1'b1, cihp_pkg::ST_OK);
         end
         return;
      end
      if (phase == P_NAME) begin
         if (name_left > 0) name_left = name_left - 1'b1;
         if (name_left == 0) phase = P_UUIDHI;
         push_word(cihp_pkg::FC_NAME, {56'd0, b}, here, entry_cnt, in_req, name_left == 0,
                   cihp_pkg::ST_OK);
         return;
      end
      if (phase == P_DEPSKIP) begin
         if (skip_left > 0) skip_left = skip_left - 1'b1;
         if (skip_left != 0) return;
         start_list(1'b1);
         push_word(cihp_pkg::FC_DEPLEN, acc + 64'd8, fstart, '0, 1'b0, 1'b0, cihp_pkg::ST_OK);
         return;
      end
      if (byte_cnt == 0) begin
         fstart = here;
         acc    = '0;
      end
      if (byte_cnt < 8) acc = acc | (64'(b) << (8 * byte_cnt));
      byte_cnt++;
      case (phase)
         P_MAGIC:                  nbytes = cihp_pkg::MAGIC_BYTES_DEF;
         P_VERSION, P_MARK:        nbytes = 2;
         P_PTR, P_IMAGE, P_FLAGS:  nbytes = 1;
         P_NAMELEN:                nbytes = 4;
         default:                  nbytes = 8;
      endcase
      if (byte_cnt >= nbytes) close_field();
   endtask

   always @(posedge clock) begin
      cihp_pkg::rsp_word_type want;
      if (reset) begin
         magic_reg   = '0;
         mark_reg    = 16'hFEFF;
         min_ver_reg = '0;
         tag_reg     = '0;
         clear_parse();
         field_words_q.delete();
         mismatches  = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               cihp_pkg::CSR_MAGIC:   magic_reg   = csr_wdata;
               cihp_pkg::CSR_MARK:    mark_reg    = csr_wdata[15:0];
               cihp_pkg::CSR_MIN_VER: min_ver_reg = csr_wdata[15:0];
               cihp_pkg::CSR_CHK_TAG: tag_reg     = csr_wdata[31:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (field_words_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result word: %p", rsp_word);
            end else begin
               want = field_words_q.pop_front();
               if (rsp_word.field_code !== want.field_code ||
                   rsp_word.field_value !== want.field_value ||
                   rsp_word.field_offset !== want.field_offset ||
                   rsp_word.module_number !== want.module_number ||
                   rsp_word.list_select !== want.list_select ||
                   rsp_word.string_last !== want.string_last ||
                   rsp_word.status !== want.status) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("result mismatch: expected %p got %p", want, rsp_word);
               end
            end
         end
         if (req_valid && req_ready) parse_word(req_kind, req_data_byte);
      end
   end

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives cache image headers (well formed, truncated, corrupted and noise)
// through the parser under several register settings and idle patterns; the
// checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module testbench;

   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int FILL_ZERO = 0;
   localparam int FILL_ONES = 1;
   localparam int FILL_RAND = 2;
   localparam int FAULT_NONE  = 0;
   localparam int FAULT_TRUNC = 1;
   localparam int FAULT_MAGIC = 2;
   localparam int FAULT_MARK  = 3;
   localparam int FAULT_NAME  = 4;
   localparam int FAULT_NOISE = 5;

   logic clock;
   logic reset;
   logic csr_we;
   logic [cihp_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [cihp_pkg::CSR_DATA_W-1:0] csr_wdata;
   int   mismatches;
   int   pending;
   int   send_idle;
   int   recv_stall;
   int   word_count;

   logic [63:0] cfg_magic;
   logic [15:0] cfg_mark;
   logic [31:0] cfg_tag;

   logic [9:0] byte_stream_q[$];

   cihp_stream_if #(.W(10))              req_ch ();
   cihp_stream_if #(.W(cihp_pkg::RSP_W)) rsp_ch ();

   cache_image_header_parser_unit u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_ch.valid),
      .req_ready         (req_ch.ready),
      .req_kind          (req_ch.payload[9:8]),
      .req_data_byte     (req_ch.payload[7:0]),
      .rsp_valid         (rsp_ch.valid),
      .rsp_ready         (rsp_ch.ready),
      .rsp_field_code    (rsp_ch.payload[152:148]),
      .rsp_field_value   (rsp_ch.payload[147:84]),
      .rsp_field_offset  (rsp_ch.payload[83:21]),
      .rsp_module_number (rsp_ch.payload[20:5]),
      .rsp_list_select   (rsp_ch.payload[4]),
      .rsp_string_last   (rsp_ch.payload[3]),
      .rsp_status        (rsp_ch.payload[2:0]),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   cihp_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_ch.valid),
      .req_ready     (req_ch.ready),
      .req_kind      (req_ch.payload[9:8]),
      .req_data_byte (req_ch.payload[7:0]),
      .rsp_valid     (rsp_ch.valid),
      .rsp_ready     (rsp_ch.ready),
      .rsp_word      (cihp_pkg::rsp_word_type'(rsp_ch.payload)),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .mismatches    (mismatches),
      .pending       (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("TB_ERROR");
      $finish;
   end

   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall);
   end

   function automatic logic [63:0] pick(int fill);
      if (fill == FILL_ZERO) return '0;
      if (fill == FILL_ONES) return '1;
      return {$urandom, $urandom};
   endfunction

   task automatic put_le(logic [63:0] value, int n);
      for (int i = 0; i < n; i++)
         byte_stream_q.push_back({cihp_pkg::KIND_DATA, value[8*i +: 8]});
   endtask

   task automatic put_entry(int fill, logic required, ref int namelen_at);
      int len;
      len = (fill == FILL_RAND) ? $urandom_range(1, 3) : 2;
      if (namelen_at < 0) namelen_at = byte_stream_q.size();
      put_le(64'(len), 4);
      for (int i = 0; i < len; i++) put_le(pick(fill), 1);
      put_le(pick(fill), 8);
      put_le(pick(fill), 8);
      if (required) put_le(pick(fill), 8);
      put_le(pick(fill), 8);
   endtask

   task automatic build_header(int fill, int fault);
      int start;
      int namelen_at;
      int n;
      int cut;
      logic [63:0] v;
      logic has_image;
      start      = byte_stream_q.size();
      namelen_at = -1;
      byte_stream_q.push_back({cihp_pkg::KIND_RESTART, 8'($urandom)});
      put_le(cfg_magic, cihp_pkg::MAGIC_BYTES_DEF);
      put_le(pick(fill), 2);
      put_le({48'd0, cfg_mark}, 2);
      put_le(pick(fill), 1);
      for (int s = 0; s < cihp_pkg::NUM_STRINGS; s++) begin
         n = (fill == FILL_RAND) ? $urandom_range(0, 3) : (fill == FILL_ONES ? 2 : 0);
         for (int i = 0; i < n; i++)
            put_le(fill == FILL_ONES ? 64'hFF : 64'($urandom_range(1, 255)), 1);
         put_le(64'd0, 1);
      end
      if (fill == FILL_RAND)
         v = ($urandom_range(3) == 0) ? 64'($urandom_range(255)) : 64'($urandom_range(1));
      else
         v = pick(fill);
      has_image = (v[7:0] != 0);
      put_le(v, 1);
      v = pick(fill);
      if (fill == FILL_RAND) begin
         case ($urandom_range(2))
            0: v[63:32] = '0;
            1: v[63:32] = cfg_tag;
            default: ;
         endcase
      end
      put_le(v, 8);
      put_le(pick(fill), 8);
      put_le(pick(fill), 8);
      put_le(pick(fill), 1);
      if (!has_image) begin
         n = (fill == FILL_RAND) ? $urandom_range(0, 2) : 1;
         for (int e = 0; e < n; e++) put_entry(fill, 1'b0, namelen_at);
         put_le(64'd0, 4);
         n = (fill == FILL_RAND) ? $urandom_range(0, 4) : 0;
         put_le(64'(n), 8);
         for (int i = 0; i < n; i++) put_le(64'($urandom), 1);
      end
      n = (fill == FILL_RAND) ? $urandom_range(0, 2) : 1;
      for (int e = 0; e < n; e++) put_entry(fill, 1'b1, namelen_at);
      put_le(64'd0, 4);
      byte_stream_q.push_back({cihp_pkg::KIND_END, 8'($urandom)});
      case (fault)
         FAULT_TRUNC: begin
            cut = $urandom_range(start + 1, byte_stream_q.size() - 2);
            while (byte_stream_q.size() > cut) void'(byte_stream_q.pop_back());
            byte_stream_q.push_back({cihp_pkg::KIND_END, 8'($urandom)});
         end
         FAULT_MAGIC: begin
            cut = start + 1 + $urandom_range(cihp_pkg::MAGIC_BYTES_DEF - 1);
            byte_stream_q[cut][7:0] = byte_stream_q[cut][7:0] ^ 8'($urandom_range(1, 255));
         end
         FAULT_MARK: begin
            cut = start + 1 + cihp_pkg::MAGIC_BYTES_DEF + 2 + $urandom_range(1);
            byte_stream_q[cut][7:0] = byte_stream_q[cut][7:0] ^ 8'($urandom_range(1, 255));
         end
         FAULT_NAME: begin
            if (namelen_at >= 0) byte_stream_q[namelen_at + 3][7] = 1'b1;
         end
         FAULT_NOISE: begin
            for (int i = 0; i < 20; i++)
               byte_stream_q.push_back({2'($urandom_range(3)), 8'($urandom)});
         end
         default: ;
      endcase
   endtask

   task automatic send_stream();
      logic [9:0] w;
      while (byte_stream_q.size() > 0) begin
         w = byte_stream_q.pop_front();
         while ($urandom_range(99) < send_idle) begin
            req_ch.valid <= 1'b0;
            @(posedge clock);
         end
         req_ch.valid   <= 1'b1;
         req_ch.payload <= w;
         @(posedge clock);
         while (!req_ch.ready) @(posedge clock);
         word_count++;
      end
      req_ch.valid <= 1'b0;
   endtask

   task automatic drain();
      int waited;
      waited = 0;
      while (pending != 0) begin
         @(posedge clock);
         waited++;
         if (waited > 200_000) begin
            $display("TB_ERROR");
            $finish;
         end
      end
      repeat (10) @(posedge clock);
   endtask

   task automatic write_regs(logic [63:0] magic, logic [15:0] mark, logic [15:0] min_ver,
                             logic [31:0] tag);
      cfg_magic = magic;
      cfg_mark  = mark;
      cfg_tag   = tag;
      csr_we    <= 1'b1;
      csr_index <= cihp_pkg::CSR_MAGIC;
      csr_wdata <= magic;
      @(posedge clock);
      csr_index <= cihp_pkg::CSR_MARK;
      csr_wdata <= {48'd0, mark};
      @(posedge clock);
      csr_index <= cihp_pkg::CSR_MIN_VER;
      csr_wdata <= {48'd0, min_ver};
      @(posedge clock);
      csr_index <= cihp_pkg::CSR_CHK_TAG;
      csr_wdata <= {32'd0, tag};
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      int fault;
      int roll;
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;
      req_ch.valid   = 1'b0;
      req_ch.payload = '0;
      rsp_ch.ready   = 1'b0;
      send_idle      = 16;
      recv_stall     = 78;
      word_count     = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int p = 0; p < 6; p++) begin
         case (p / 2)
            0: begin send_idle = 16; recv_stall = 78; end
            1: begin send_idle = 78; recv_stall = 16; end
            default: begin send_idle = 0; recv_stall = 0; end
         endcase
         drain();
         case (p)
            0: write_regs('0, 16'hFEFF, '0, '0);
            1: write_regs('1, 16'h0000, 16'hFFFF, 32'hFFFF_FFFF);
            default: write_regs({$urandom, $urandom}, 16'($urandom), 16'($urandom),
                                $urandom);
         endcase
         if (p == 0) begin
            // end of stream at the very first position, then an unused kind
            byte_stream_q.push_back({cihp_pkg::KIND_END, 8'h00});
            byte_stream_q.push_back({KIND_UNUSED, 8'hFF});
            build_header(FILL_ZERO, FAULT_NONE);
            build_header(FILL_ONES, FAULT_NONE);
            build_header(FILL_RAND, FAULT_MAGIC);
            build_header(FILL_RAND, FAULT_MARK);
            build_header(FILL_RAND, FAULT_NAME);
            build_header(FILL_RAND, FAULT_TRUNC);
            send_stream();
         end
         word_count = 0;
         while (word_count < 40) begin
            roll = $urandom_range(99);
            if (roll < 60)      fault = FAULT_NONE;
            else if (roll < 72) fault = FAULT_TRUNC;
            else if (roll < 80) fault = FAULT_MAGIC;
            else if (roll < 86) fault = FAULT_MARK;
            else if (roll < 94) fault = FAULT_NAME;
            else                fault = FAULT_NOISE;
            build_header(FILL_RAND, fault);
            send_stream();
         end
      end

      drain();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
